[rtl/tnc_pkg.sv]
package tnc_pkg;

  // field widths
  localparam int CW  = 24;          // coordinate width
  localparam int NF  = 14;          // fraction bits of the unit normal
  localparam int UNW = NF + 2;      // unit normal component width

  // internal widths
  localparam int EW  = CW + 1;      // edge vector component
  localparam int PRW = 2 * EW;      // edge product
  localparam int DW  = PRW + 1;     // difference of two products
  localparam int MW  = 2 * CW + 1;  // cross product magnitude
  localparam int HL  = (MW + 1) / 2;
  localparam int HH  = MW - HL;
  localparam int C2W = 2 * MW;      // squared component
  localparam int L2W = C2W + 2;     // squared length
  localparam int WW  = L2W + 2 * NF + 4;
  localparam int SW  = CW + 2;      // vertex sum
  localparam int UW  = CW + 2;      // rounding operand of the centroid
  localparam int RS  = UW + 1;
  localparam logic [RS-1:0] RECIP3 = RS'((64'd1 << RS) / 64'd3);

  typedef struct packed {
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic signed [CW-1:0] c_x;
    logic signed [CW-1:0] c_y;
    logic signed [CW-1:0] c_z;
  } tri_t;

  typedef struct packed {
    logic signed [CW-1:0]  mid_x;
    logic signed [CW-1:0]  mid_y;
    logic signed [CW-1:0]  mid_z;
    logic signed [UNW-1:0] unit_x;
    logic signed [UNW-1:0] unit_y;
    logic signed [UNW-1:0] unit_z;
    logic                  degenerate;
  } res_t;

  // state of the per-bit search for the rounded unit components
  typedef struct packed {
    logic [2:0][WW-1:0] p;    // (2k-1)^2 * len2
    logic [2:0][WW-1:0] q;    // (2k-1) * len2, two's complement
    logic [2:0][WW-1:0] rhs;  // 4 * c^2 * 2^(2*NF)
    logic [2:0][NF:0]   k;
    logic [L2W-1:0]     l2;
    logic [2:0]         neg;
    logic               degen;
    logic [2:0][CW-1:0] mid;
  } iter_t;

endpackage

[rtl/tnc_bit_step.sv]
module tnc_bit_step import tnc_pkg::*; #(
  parameter int J = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_v,
  input  iter_t st_in,
  output logic  out_v,
  output iter_t st_out
);

  iter_t          st_next;
  logic [WW-1:0]  cand;
  logic [WW-1:0]  l2w;

  // try bit J of each component: grow (2k-1)^2*len2 by shifts and adds
  always_comb begin
    st_next = st_in;
    l2w     = WW'(st_in.l2);
    cand    = '0;
    for (int i = 0; i < 3; i++) begin
      cand = st_in.p[i] + (st_in.q[i] << (J + 2)) + (l2w << (2 * J + 2));
      if (cand <= st_in.rhs[i]) begin
        st_next.k[i][J] = 1'b1;
        st_next.p[i]    = cand;
        st_next.q[i]    = st_in.q[i] + (l2w << (J + 1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_out <= st_next;
    end
  end

endmodule

[rtl/triangle_normal_centroid.sv]
// Triangle face normal and centroid.
// Input channel in_valid/in_stall/in_data carries one triangle per item:
// three vertices in signed Q12.12. Output channel out_valid/out_stall/
// out_data carries one result per triangle: the centroid (rounded to
// nearest, Q12.12), the unit normal of (b-a)x(c-a) in signed Q1.14
// rounded to nearest, and a degenerate flag that zeroes the normal.
// The pipeline has six stages for edges, cross products, squares and the
// squared length, fifteen stages that each settle one bit of the rounded
// unit components, and the output register. One item enters per cycle
// unless the output stalls; the pipeline holds no state between items.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall rises, so nothing is lost or repeated; bubbles are not squeezed.
// Synchronous reset clears all valid bits; payload registers are not reset.
module triangle_normal_centroid import tnc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  tri_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_data
);

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  // stage 1: edges and sums
  logic signed [CW-1:0]  va [3];
  logic signed [CW-1:0]  vb [3];
  logic signed [CW-1:0]  vc [3];
  logic                  s1_v;
  logic signed [EW-1:0]  e1 [3];
  logic signed [EW-1:0]  e2 [3];
  logic signed [SW-1:0]  sum [3];

  always_comb begin
    va[0] = in_data.a_x; va[1] = in_data.a_y; va[2] = in_data.a_z;
    vb[0] = in_data.b_x; vb[1] = in_data.b_y; vb[2] = in_data.b_z;
    vc[0] = in_data.c_x; vc[1] = in_data.c_y; vc[2] = in_data.c_z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1[i]  <= EW'(vb[i]) - EW'(va[i]);
        e2[i]  <= EW'(vc[i]) - EW'(va[i]);
        sum[i] <= SW'(va[i]) + SW'(vb[i]) + SW'(vc[i]);
      end
    end
  end

  // stage 2: edge products, centroid reciprocal product
  logic                  s2_v;
  logic signed [PRW-1:0] m1 [3];
  logic signed [PRW-1:0] m2 [3];
  logic [UW-1:0]         s2_u [3];
  logic [UW+RS-1:0]      s2_prod [3];
  logic [2:0]            s2_cneg;
  logic [UW-1:0]         u [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u[i] = (sum[i] < 0) ? UW'(-sum[i]) + UW'(1) : UW'(sum[i]) + UW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1[0] <= PRW'(e1[1]) * PRW'(e2[2]);
      m2[0] <= PRW'(e1[2]) * PRW'(e2[1]);
      m1[1] <= PRW'(e1[2]) * PRW'(e2[0]);
      m2[1] <= PRW'(e1[0]) * PRW'(e2[2]);
      m1[2] <= PRW'(e1[0]) * PRW'(e2[1]);
      m2[2] <= PRW'(e1[1]) * PRW'(e2[0]);
      for (int i = 0; i < 3; i++) begin
        s2_u[i]    <= u[i];
        s2_prod[i] <= (UW+RS)'(u[i]) * (UW+RS)'(RECIP3);
        s2_cneg[i] <= sum[i] < 0;
      end
    end
  end

  // stage 3: cross product magnitude and sign, centroid estimate
  logic                  s3_v;
  logic [MW-1:0]         mag [3];
  logic [2:0]            s3_neg;
  logic [UW-1:0]         s3_u [3];
  logic [UW-1:0]         q0 [3];
  logic [2:0]            s3_cneg;
  logic signed [DW-1:0]  d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d[i] = DW'(m1[i]) - DW'(m2[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s3_neg[i]  <= d[i] < 0;
        mag[i]     <= (d[i] < 0) ? MW'(-d[i]) : MW'(d[i]);
        s3_u[i]    <= s2_u[i];
        q0[i]      <= UW'(s2_prod[i] >> RS);
        s3_cneg[i] <= s2_cneg[i];
      end
    end
  end

  // stage 4: partial squares, centroid correction
  logic                  s4_v;
  logic [2*HH-1:0]       sq_hh [3];
  logic [HH+HL-1:0]      sq_hl [3];
  logic [2*HL-1:0]       sq_ll [3];
  logic [2:0]            s4_neg;
  logic [2:0][CW-1:0]    s4_mid;
  logic [UW-1:0]         rem [3];
  logic [UW-1:0]         quo [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem[i] = s3_u[i] - ((q0[i] << 1) + q0[i]);
      quo[i] = (rem[i] >= UW'(3)) ? q0[i] + UW'(1) : q0[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_hh[i]  <= (2*HH)'(mag[i][MW-1:HL]) * (2*HH)'(mag[i][MW-1:HL]);
        sq_hl[i]  <= (HH+HL)'(mag[i][MW-1:HL]) * (HH+HL)'(mag[i][HL-1:0]);
        sq_ll[i]  <= (2*HL)'(mag[i][HL-1:0]) * (2*HL)'(mag[i][HL-1:0]);
        s4_neg[i] <= s3_neg[i];
        s4_mid[i] <= s3_cneg[i] ? CW'(-quo[i]) : CW'(quo[i]);
      end
    end
  end

  // stage 5: squared components
  logic                  s5_v;
  logic [C2W-1:0]        c2 [3];
  logic [2:0]            s5_neg;
  logic [2:0][CW-1:0]    s5_mid;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c2[i] <= (C2W'(sq_hh[i]) << (2 * HL)) + (C2W'(sq_hl[i]) << (HL + 1))
               + C2W'(sq_ll[i]);
      end
      s5_neg <= s4_neg;
      s5_mid <= s4_mid;
    end
  end

  // stage 6: squared length, search setup
  logic                  s6_v;
  iter_t                 s6_st;
  iter_t                 init;
  logic [L2W-1:0]        l2;

  always_comb begin
    l2         = L2W'(c2[0]) + L2W'(c2[1]) + L2W'(c2[2]);
    init.l2    = l2;
    init.neg   = s5_neg;
    init.mid   = s5_mid;
    init.degen = (l2 == '0);
    for (int i = 0; i < 3; i++) begin
      init.p[i]   = WW'(l2);
      init.q[i]   = WW'(0) - WW'(l2);
      init.rhs[i] = WW'(c2[i]) << (2 * NF + 2);
      init.k[i]   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_st <= init;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      s6_v <= s5_v;
    end
  end

  // one stage per bit of the unit components, most significant first
  iter_t chain [NF+2];
  logic  chain_v [NF+2];

  assign chain[0]   = s6_st;
  assign chain_v[0] = s6_v;

  for (genvar g = 0; g <= NF; g++) begin : g_bit
    tnc_bit_step #(
      .J(NF - g)
    ) u_step (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .in_v  (chain_v[g]),
      .st_in (chain[g]),
      .out_v (chain_v[g+1]),
      .st_out(chain[g+1])
    );
  end

  // output register
  iter_t fin;
  res_t  res_next;
  logic  [UNW-1:0] un [3];

  assign fin = chain[NF+1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (fin.degen) begin
        un[i] = '0;
      end else if (fin.neg[i]) begin
        un[i] = UNW'(0) - UNW'(fin.k[i]);
      end else begin
        un[i] = UNW'(fin.k[i]);
      end
    end
    res_next.mid_x      = fin.mid[0];
    res_next.mid_y      = fin.mid[1];
    res_next.mid_z      = fin.mid[2];
    res_next.unit_x     = un[0];
    res_next.unit_y     = un[1];
    res_next.unit_z     = un[2];
    res_next.degenerate = fin.degen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= chain_v[NF+1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= res_next;
    end
  end

endmodule

[rtl/tnc_check.sv]
module tnc_check import tnc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input tri_t in_data,
  input logic out_valid,
  input logic out_stall,
  input res_t out_data
);

  localparam logic signed [UNW-1:0] ONE  = UNW'(1) << NF;
  localparam logic signed [UNW-1:0] MONE = -(UNW'(1) << NF);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // input backs up only behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

  // no pending result means the input is open
  a_in_open: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while output empty");

  // degenerate triangle gives zero normal
  a_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.degenerate |->
      out_data.unit_x == '0 && out_data.unit_y == '0 && out_data.unit_z == '0)
    else $error("degenerate result with nonzero normal");

  // unit components stay within plus or minus one
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      out_data.unit_x <= ONE && out_data.unit_x >= MONE &&
      out_data.unit_y <= ONE && out_data.unit_y >= MONE &&
      out_data.unit_z <= ONE && out_data.unit_z >= MONE)
    else $error("unit normal component out of range");

endmodule

bind triangle_normal_centroid tnc_check u_check (.*);
